// File: rtl/core/length_prefixed_frame_deframer_defines.svh
// Assertion helpers for the checker file.
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_DEFINES_SVH

// Clocked assertion, off while reset is asserted.
`define LPFD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define LPFD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/lpfd_pkg.sv
package lpfd_pkg;

  localparam int LENGTH_BITS = 10;
  // frame length register also holds the raw low header byte
  localparam int FRAME_W     = (LENGTH_BITS > 8) ? LENGTH_BITS : 8;
  localparam int MSG_LEN_W   = 10;
  localparam int BYTE_W      = 8;
  localparam int OUT_DATA_W  = ((BYTE_W + MSG_LEN_W + 7) / 8) * 8;

  typedef enum logic {
    OP_BYTE  = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_ABORT = 2'd2
  } kind_t;

  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] data;
  } item_t;

  typedef struct packed {
    logic                 valid;
    kind_t                kind;
    logic [BYTE_W-1:0]    payload;
    logic [MSG_LEN_W-1:0] msg_len;
    logic                 last;
  } result_t;

endpackage

// File: rtl/core/lpfd_parser.sv
module lpfd_parser
  import lpfd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  item_t   item,
  output result_t res
);

  typedef enum logic [1:0] {
    PH_LOW  = 2'd0,
    PH_HIGH = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [FRAME_W-1:0]     frame_len_r, frame_len_nxt;
  logic [LENGTH_BITS-1:0] count_r, count_nxt;

  logic [LENGTH_BITS-1:0] hdr_len;
  logic [LENGTH_BITS-1:0] count_inc;
  logic                   is_last;

  assign hdr_len   = LENGTH_BITS'({item.data, frame_len_r[7:0]});
  assign count_inc = count_r + 1'b1;
  assign is_last   = (FRAME_W'(count_inc) == frame_len_r);

  always_comb begin
    phase_nxt     = phase_r;
    frame_len_nxt = frame_len_r;
    count_nxt     = count_r;
    res           = '{valid: 1'b0, kind: KIND_DATA, payload: '0, msg_len: '0, last: 1'b0};

    if (item.op == OP_FLUSH) begin
      if (phase_r == PH_HIGH || phase_r == PH_DATA) begin
        res = '{valid: 1'b1, kind: KIND_ABORT, payload: '0,
                msg_len: MSG_LEN_W'(frame_len_r), last: 1'b1};
      end
      phase_nxt     = PH_LOW;
      frame_len_nxt = '0;
      count_nxt     = '0;
    end else begin
      case (phase_r)
        PH_HIGH: begin
          frame_len_nxt = FRAME_W'(hdr_len);
          count_nxt     = '0;
          if (hdr_len == '0) begin
            phase_nxt = PH_LOW;
            res = '{valid: 1'b1, kind: KIND_EMPTY, payload: '0, msg_len: '0, last: 1'b1};
          end else begin
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA: begin
          count_nxt = count_inc;
          res = '{valid: 1'b1, kind: KIND_DATA, payload: item.data,
                  msg_len: MSG_LEN_W'(frame_len_r), last: is_last};
          if (is_last) phase_nxt = PH_LOW;
        end
        default: begin
          // low header byte
          frame_len_nxt = FRAME_W'(item.data);
          count_nxt     = '0;
          phase_nxt     = PH_HIGH;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LOW;
      frame_len_r <= '0;
      count_r     <= '0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      frame_len_r <= frame_len_nxt;
      count_r     <= count_nxt;
    end
  end

endmodule

// File: rtl/core/length_prefixed_frame_deframer.sv
// Length-prefixed frame deframer.
// Input stream: one transaction per received byte (in_tuser = 0) or an
// empty-packet event (in_tuser = 1) that returns the parser to the header.
// Each message is a little-endian 16-bit length, masked to LENGTH_BITS,
// followed by that many payload bytes. Only a zero-length header produces output.
// Output stream: one transaction per payload byte (kind data), one for a
// zero-length message (kind empty) and one when an empty packet cuts a
// message short (kind abort). out_tlast marks the final byte of a message
// and every empty or aborted message.
// Path: a byte is held in the input register, and its result in the output register.
// Throughput: one input transaction per cycle when not stalled, set by the
// input register feeding the parser state and result register in a single pass.
// Reset: synchronous, active low; clears the parser to await a low length
// byte and empties both registers.
// Stall: while out_tready is low a held result stays put; one more item
// is held in the input register, then in_tready drops.
module length_prefixed_frame_deframer
  import lpfd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [BYTE_W-1:0]     in_tdata,   // [7:0] stream_byte
  input  logic                  in_tuser,   // [0] operation
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [7:0] payload_byte, [17:8] message_length
  output logic [1:0]            out_tuser,  // [1:0] kind
  output logic                  out_tlast
);

  logic    in_valid_r;
  item_t   in_item_r;
  logic    out_valid_r;
  result_t out_res_r;
  result_t res;
  logic    advance;
  logic    step;

  assign advance   = !out_valid_r || out_tready;
  assign step      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r <= '{op: op_t'(in_tuser), data: in_tdata};
    end
  end

  lpfd_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (in_item_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({out_res_r.msg_len, out_res_r.payload});
  assign out_tuser  = out_res_r.kind;
  assign out_tlast  = out_res_r.last;

endmodule

// File: rtl/core/lpfd_checker.sv
`include "length_prefixed_frame_deframer_defines.svh"

module lpfd_props
  import lpfd_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]            out_tuser,
  input logic                  out_tlast
);

  `LPFD_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled output transaction changed")
  `LPFD_ASSERT(a_empty_shape, clk, rst_n, out_tvalid && out_tuser == KIND_EMPTY |-> out_tlast && out_tdata == '0, "empty message must be last with zero data and length")
  `LPFD_ASSERT(a_abort_shape, clk, rst_n, out_tvalid && out_tuser == KIND_ABORT |-> out_tlast && out_tdata[BYTE_W-1:0] == '0, "abort must be last with zero payload")
  `LPFD_ASSERT(a_in_stall, clk, rst_n, !in_tready |-> out_tvalid && !out_tready, "input stalled without a held output")
  `LPFD_ASSERT_ALWAYS(a_reset_empty, clk, $past(!rst_n) |-> !out_tvalid, "output valid right after reset")

endmodule

bind length_prefixed_frame_deframer lpfd_props u_lpfd_checker (.*);
